/* hdl/ttfc_pkg.sv */
`timescale 1ns / 1ps

package ttfc_pkg;

  localparam int unsigned CoordBitsDefault = 13;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned CfgIndexW = 3;

  localparam logic [CfgIndexW-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_PITCH_PIXELS = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_TILED_LAYOUT = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_ENDIAN_MODE  = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_TEXEL_FORMAT = 3'd4;

  localparam logic [5:0] FMT_8888      = 6'd6;
  localparam logic [5:0] FMT_1010102   = 6'd7;
  localparam logic [5:0] FMT_8888_A    = 6'd14;
  localparam logic [5:0] FMT_8888_W    = 6'd50;
  localparam logic [5:0] FMT_1010102_W = 6'd54;

  localparam logic [13:0] FRAME_WIDTH_RESET = 14'd1280;
  localparam logic [5:0]  TEXEL_FORMAT_RESET = FMT_8888;

  typedef enum logic [1:0] {
    ENDIAN_NONE   = 2'd0,
    ENDIAN_SWAP16 = 2'd1,
    ENDIAN_SWAP32 = 2'd2,
    ENDIAN_HALVES = 2'd3
  } endian_e;

  function automatic logic [31:0] undo_endian(input logic [31:0] w, input endian_e mode);
    logic [31:0] r;
    unique case (mode)
      ENDIAN_SWAP16: r = {w[23:16], w[31:24], w[7:0], w[15:8]};
      ENDIAN_SWAP32: r = {w[7:0], w[15:8], w[23:16], w[31:24]};
      ENDIAN_HALVES: r = {w[15:0], w[31:16]};
      default:       r = w;
    endcase
    return r;
  endfunction

  // Tiled offset given the macro-tile row product (y / 32) * macro tiles per row.
  function automatic logic [31:0] tile_offset(input logic [31:0] x, input logic [31:0] y,
                                              input logic [31:0] row_prod);
    logic [31:0] macro;
    logic [31:0] micro;
    logic [31:0] base;
    logic [31:0] bank;
    macro = ((x >> 5) + row_prod) << 9;
    micro = ((x & 32'd7) + ((y & 32'd6) << 2)) << 2;
    base  = macro + ((micro & ~32'd15) << 1) + (micro & 32'd15)
          + ((y & 32'd8) << 5) + ((y & 32'd1) << 4);
    bank  = ((((y & 32'd8) >> 2) + (x >> 3)) & 32'd3) << 6;
    return ((base & ~32'd511) << 3) + ((base & 32'd448) << 2) + (base & 32'd63)
         + ((y & 32'd16) << 7) + bank;
  endfunction

endpackage

/* hdl/tiled_texel_fetch_convert.sv */
`timescale 1ns / 1ps

// A taken request passes the input, stage-two and result registers before the result strobe rises.
// Throughput: one request per clock; busy stays low and the block never stalls.
// The three stages are the input register, the shared coordinate multiplier and the
// offset adders, which end in the result register.
// Reset clears the stage valid bits and loads the register defaults.
module tiled_texel_fetch_convert #(
  parameter int unsigned COORD_BITS = ttfc_pkg::CoordBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [COORD_BITS-1:0]          pixel_x_i,
  input  logic [COORD_BITS-1:0]          pixel_y_i,
  input  logic [31:0]                    raw_texel_i,
  output logic                           done_o,
  output logic [31:0]                    byte_offset_o,
  output logic [31:0]                    pixel_bgra_o,
  output logic                           format_supported_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ttfc_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [ttfc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import ttfc_pkg::*;

  localparam int unsigned ProdW = COORD_BITS + CfgDataW;

  logic [13:0] frame_width_q;
  logic [13:0] pitch_pixels_q;
  logic        tiled_layout_q;
  endian_e     endian_mode_q;
  logic [5:0]  texel_format_q;

  logic                  s1_valid_q;
  logic [COORD_BITS-1:0] s1_x_q;
  logic [COORD_BITS-1:0] s1_y_q;
  logic [31:0]           s1_word_q;

  logic                  s2_valid_q;
  logic [COORD_BITS-1:0] s2_x_q;
  logic [COORD_BITS-1:0] s2_y_q;
  logic [ProdW-1:0]      s2_prod_q;
  logic [ProdW-1:0]      s2_prod_d;
  logic [31:0]           s2_pixel_q;
  logic [31:0]           s2_pixel_d;
  logic                  s2_supported_q;
  logic                  s2_supported_d;

  logic        out_valid_q;
  logic [31:0] out_offset_q;
  logic [31:0] out_offset_d;
  logic [31:0] out_pixel_q;
  logic        out_supported_q;

  logic                  accept;
  logic [13:0]           pitch;
  logic [14:0]           pitch_round;
  logic [13:0]           tiles_per_row;
  logic [COORD_BITS-1:0] mul_a;
  logic [13:0]           mul_b;
  logic [31:0]           texel;
  logic [31:0]           linear_sum;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RESET;
      pitch_pixels_q <= '0;
      tiled_layout_q <= 1'b1;
      endian_mode_q  <= ENDIAN_NONE;
      texel_format_q <= TEXEL_FORMAT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_PITCH_PIXELS: pitch_pixels_q <= cfg_data_i;
        CFG_TILED_LAYOUT: tiled_layout_q <= cfg_data_i[0];
        CFG_ENDIAN_MODE:  endian_mode_q  <= endian_e'(cfg_data_i[1:0]);
        CFG_TEXEL_FORMAT: texel_format_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // Stage two: one multiplier serves both layouts.
  always_comb begin
    pitch         = (pitch_pixels_q != '0) ? pitch_pixels_q : frame_width_q;
    pitch_round   = {1'b0, pitch} + 15'd31;
    tiles_per_row = {4'd0, pitch_round[14:5]};
    mul_a         = tiled_layout_q ? (s1_y_q >> 5) : s1_y_q;
    mul_b         = tiled_layout_q ? tiles_per_row : pitch;
    s2_prod_d     = ProdW'(mul_a) * ProdW'(mul_b);
  end

  always_comb begin
    texel = undo_endian(s1_word_q, endian_mode_q);
    unique case (texel_format_q)
      FMT_1010102, FMT_1010102_W: begin
        // Two-bit alpha times 85 is the pair repeated four times.
        s2_pixel_d     = {{4{texel[31:30]}}, texel[9:2], texel[19:12], texel[29:22]};
        s2_supported_d = 1'b1;
      end
      FMT_8888, FMT_8888_A, FMT_8888_W: begin
        s2_pixel_d     = {texel[31:24], texel[7:0], texel[15:8], texel[23:16]};
        s2_supported_d = 1'b1;
      end
      default: begin
        s2_pixel_d     = '0;
        s2_supported_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    linear_sum = 32'(s2_prod_q) + 32'(s2_x_q);
    if (tiled_layout_q) begin
      out_offset_d = tile_offset(32'(s2_x_q), 32'(s2_y_q), 32'(s2_prod_q));
    end else begin
      out_offset_d = linear_sum << 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q    <= pixel_x_i;
      s1_y_q    <= pixel_y_i;
      s1_word_q <= raw_texel_i;
    end
    s2_x_q          <= s1_x_q;
    s2_y_q          <= s1_y_q;
    s2_prod_q       <= s2_prod_d;
    s2_pixel_q      <= s2_pixel_d;
    s2_supported_q  <= s2_supported_d;
    out_offset_q    <= out_offset_d;
    out_pixel_q     <= s2_pixel_q;
    out_supported_q <= s2_supported_q;
  end

  assign done_o             = out_valid_q;
  assign byte_offset_o      = out_offset_q;
  assign pixel_bgra_o       = out_pixel_q;
  assign format_supported_o = out_supported_q;

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##2 done_o)
    else $error("Taken request did not produce a result three cycles later.");

  a_no_request_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> ##2 !done_o)
    else $error("Result strobe without a matching request.");

  a_unsupported_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !format_supported_o) |-> (pixel_bgra_o == 32'd0))
    else $error("Unsupported format produced a nonzero pixel.");

  a_offset_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (byte_offset_o[1:0] == 2'b00))
    else $error("Byte offset is not texel aligned.");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ttfc_pkg::*;

  localparam int unsigned CoordBits = CoordBitsDefault;
  localparam logic [CoordBits-1:0] CoordMax = '1;
  localparam logic [CfgIndexW-1:0] CFG_SPARE_FIRST = CFG_TEXEL_FORMAT + 1'b1;
  localparam logic [CfgIndexW-1:0] CFG_SPARE_LAST = '1;
  localparam logic [CfgDataW-1:0] SizeMax = 14'd8192;
  localparam int unsigned IdlePct = 24;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned RandPhases = 20;
  localparam int unsigned TexelsPerPhase = 100;

  typedef struct {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [31:0]          word;
  } texel_req_t;

  typedef struct {
    logic [31:0] offset;
    logic [31:0] bgra;
    logic        supported;
  } texel_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CoordBits-1:0] pixel_x_i = '0;
  logic [CoordBits-1:0] pixel_y_i = '0;
  logic [31:0]          raw_texel_i = '0;
  logic                 done_o;
  logic [31:0]          byte_offset_o;
  logic [31:0]          pixel_bgra_o;
  logic                 format_supported_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  logic [13:0] cfg_frame_w = FRAME_WIDTH_RESET;
  logic [13:0] cfg_pitch = '0;
  logic        cfg_tiled = 1'b1;
  endian_e     cfg_endian = ENDIAN_NONE;
  logic [5:0]  cfg_fmt = TEXEL_FORMAT_RESET;

  texel_req_t    texel_queue[$];
  texel_result_t expected_texels[$];
  texel_result_t want;
  texel_result_t got;

  bit steady = 1'b0;
  int unsigned err_count = 0;
  int unsigned n_checked = 0;
  int unsigned n_unsupported = 0;
  int unsigned n_settings = 0;
  int unsigned stall_cycles = 0;

  tiled_texel_fetch_convert #(
    .COORD_BITS(CoordBits)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .pixel_x_i         (pixel_x_i),
    .pixel_y_i         (pixel_y_i),
    .raw_texel_i       (raw_texel_i),
    .done_o            (done_o),
    .byte_offset_o     (byte_offset_o),
    .pixel_bgra_o      (pixel_bgra_o),
    .format_supported_o(format_supported_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic texel_result_t convert_texel(texel_req_t req);
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] pitch;
    logic [31:0] tiles_per_row;
    logic [31:0] macro;
    logic [31:0] micro;
    logic [31:0] base;
    logic [31:0] w;
    logic [7:0]  alpha;
    texel_result_t r;
    x = 32'(req.x);
    y = 32'(req.y);
    pitch = (cfg_pitch != '0) ? 32'(cfg_pitch) : 32'(cfg_frame_w);
    if (cfg_tiled) begin
      tiles_per_row = (pitch + 32'd31) >> 5;
      macro = ((x >> 5) + (y >> 5) * tiles_per_row) << 9;
      micro = ({29'd0, x[2:0]} + ({29'd0, y[2:1], 1'b0} << 2)) << 2;
      base = macro + ((micro & ~32'd15) << 1) + (micro & 32'd15)
           + ({28'd0, y[3], 3'd0} << 5) + ({31'd0, y[0]} << 4);
      r.offset = ((base & ~32'd511) << 3) + ((base & 32'd448) << 2) + (base & 32'd63)
               + ({27'd0, y[4], 4'd0} << 7)
               + ((((32'(y[3]) << 1) + (x >> 3)) & 32'd3) << 6);
    end else begin
      r.offset = (y * pitch + x) << 2;
    end
    case (cfg_endian)
      ENDIAN_SWAP16: w = {req.word[23:16], req.word[31:24], req.word[7:0], req.word[15:8]};
      ENDIAN_SWAP32: w = {req.word[7:0], req.word[15:8], req.word[23:16], req.word[31:24]};
      ENDIAN_HALVES: w = {req.word[15:0], req.word[31:16]};
      default:       w = req.word;
    endcase
    alpha = 8'(w[31:30]) * 8'd85;
    r.supported = 1'b1;
    if (cfg_fmt == FMT_1010102 || cfg_fmt == FMT_1010102_W) begin
      r.bgra = {alpha, w[9:2], w[19:12], w[29:22]};
    end else if (cfg_fmt == FMT_8888 || cfg_fmt == FMT_8888_A || cfg_fmt == FMT_8888_W) begin
      r.bgra = {w[31:24], w[7:0], w[15:8], w[23:16]};
    end else begin
      r.bgra = '0;
      r.supported = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_texels.push_back(convert_texel(texel_queue[0]));
        if (!expected_texels[$].supported) n_unsupported++;
        void'(texel_queue.pop_front());
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (texel_queue.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
        start <= 1'b1;
        pixel_x_i <= texel_queue[0].x;
        pixel_y_i <= texel_queue[0].y;
        raw_texel_i <= texel_queue[0].word;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      got.offset = byte_offset_o;
      got.bgra = pixel_bgra_o;
      got.supported = format_supported_o;
      if (expected_texels.size() == 0) begin
        if (err_count < MaxReports) begin
          $display("Result with no request pending: offset %h bgra %h supported %b",
                   got.offset, got.bgra, got.supported);
        end
        err_count++;
      end else begin
        want = expected_texels.pop_front();
        n_checked++;
        if (got.offset !== want.offset || got.bgra !== want.bgra ||
            got.supported !== want.supported) begin
          if (err_count < MaxReports) begin
            $display("Mismatch at %0t: offset %h/%h bgra %h/%h supported %b/%b (exp/act)",
                     $realtime, want.offset, got.offset, want.bgra, got.bgra,
                     want.supported, got.supported);
          end
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Timeout: no progress for %0d cycles", StallLimit);
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic set_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    while ($urandom_range(99) < IdlePct) @(posedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  cfg_frame_w = data;
      CFG_PITCH_PIXELS: cfg_pitch = data;
      CFG_TILED_LAYOUT: cfg_tiled = data[0];
      CFG_ENDIAN_MODE:  cfg_endian = endian_e'(data[1:0]);
      CFG_TEXEL_FORMAT: cfg_fmt = data[5:0];
      default: ;
    endcase
  endtask

  task automatic add_texel(input logic [CoordBits-1:0] x, input logic [CoordBits-1:0] y,
                           input logic [31:0] word);
    texel_req_t req;
    req.x = x;
    req.y = y;
    req.word = word;
    texel_queue.push_back(req);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (texel_queue.size() != 0 || expected_texels.size() != 0 || start) @(posedge clk_i);
    n_settings++;
  endtask

  function automatic logic [CoordBits-1:0] pick_coord();
    case ($urandom_range(9))
      0: return '0;
      1: return CoordMax;
      2: return CoordBits'($urandom_range(63));
      default: return CoordBits'($urandom);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_size(input int unsigned low);
    case ($urandom_range(3))
      0: return CfgDataW'(low);
      1: return SizeMax;
      default: return CfgDataW'($urandom_range(SizeMax, low));
    endcase
  endfunction

  function automatic logic [5:0] pick_format();
    case ($urandom_range(6))
      0: return FMT_8888;
      1: return FMT_1010102;
      2: return FMT_8888_A;
      3: return FMT_8888_W;
      4: return FMT_1010102_W;
      default: return 6'($urandom);
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_texel('0, '0, 32'h0000_0000);
    add_texel(CoordMax, CoordMax, 32'hFFFF_FFFF);
    add_texel(CoordBits'(31), CoordBits'(17), 32'h1234_5678);
    add_texel(CoordBits'(9), CoordBits'(14), 32'h8000_0001);
    wait_drained();

    set_reg(CFG_TEXEL_FORMAT, CfgDataW'(FMT_1010102));
    set_reg(CFG_ENDIAN_MODE, CfgDataW'(ENDIAN_SWAP16));
    add_texel(CoordBits'(40), CoordBits'(25), 32'hFFFF_FFFF);
    add_texel(CoordBits'(7), CoordBits'(6), 32'h4000_0000);
    add_texel(pick_coord(), pick_coord(), 32'hAAAA_5555);
    wait_drained();

    set_reg(CFG_TEXEL_FORMAT, CfgDataW'(FMT_8888_W));
    set_reg(CFG_ENDIAN_MODE, CfgDataW'(ENDIAN_SWAP32));
    set_reg(CFG_TILED_LAYOUT, '0);
    set_reg(CFG_PITCH_PIXELS, SizeMax);
    add_texel(CoordMax, CoordMax, 32'h0102_0304);
    add_texel('0, CoordMax, 32'hF0E1_D2C3);
    add_texel(CoordMax, '0, 32'h5555_AAAA);
    wait_drained();

    set_reg(CFG_TEXEL_FORMAT, CfgDataW'(FMT_1010102_W));
    set_reg(CFG_ENDIAN_MODE, CfgDataW'(ENDIAN_HALVES));
    set_reg(CFG_TILED_LAYOUT, 14'd1);
    set_reg(CFG_PITCH_PIXELS, '0);
    set_reg(CFG_FRAME_WIDTH, '0);
    add_texel(CoordMax, CoordMax, 32'h8000_C000);
    add_texel(CoordBits'(100), CoordBits'(77), 32'h3FFF_FFFF);
    add_texel(CoordBits'(5), CoordBits'(9), 32'h0000_0003);
    wait_drained();

    set_reg(CFG_TEXEL_FORMAT, CfgDataW'(FMT_8888_A));
    set_reg(CFG_ENDIAN_MODE, CfgDataW'(ENDIAN_NONE));
    set_reg(CFG_FRAME_WIDTH, SizeMax);
    set_reg(CFG_PITCH_PIXELS, 14'd1);
    set_reg(CFG_TILED_LAYOUT, '0);
    add_texel(CoordMax, CoordMax, 32'hDEAD_BEEF);
    add_texel(CoordBits'(3), CoordBits'(2), 32'h7F80_01FE);
    wait_drained();

    // Writes to unused register indexes must leave every setting unchanged.
    for (int k = CFG_SPARE_FIRST; k <= CFG_SPARE_LAST; k++) begin
      set_reg(CfgIndexW'(k), '1);
    end
    add_texel(CoordBits'(33), CoordBits'(65), 32'h1122_3344);
    wait_drained();
    set_reg(CFG_TEXEL_FORMAT, 14'd63);
    add_texel(CoordMax, CoordMax, 32'hFFFF_FFFF);
    add_texel(pick_coord(), pick_coord(), $urandom);
    wait_drained();
    set_reg(CFG_TEXEL_FORMAT, '0);
    add_texel(pick_coord(), pick_coord(), $urandom);
    add_texel('0, '0, 32'hFFFF_FFFF);
    wait_drained();

    for (int ph = 0; ph < RandPhases; ph++) begin
      steady = (ph >= 8 && ph < 12);
      if ($urandom_range(2) != 0) set_reg(CFG_FRAME_WIDTH, pick_size(1));
      if ($urandom_range(2) != 0) set_reg(CFG_PITCH_PIXELS, ($urandom_range(2) == 0) ? '0
                                                              : pick_size(0));
      if ($urandom_range(1) != 0) set_reg(CFG_TILED_LAYOUT, CfgDataW'($urandom));
      if ($urandom_range(1) != 0) set_reg(CFG_ENDIAN_MODE, CfgDataW'($urandom));
      set_reg(CFG_TEXEL_FORMAT, {8'($urandom), pick_format()});
      for (int n = 0; n < TexelsPerPhase; n++) begin
        add_texel(pick_coord(), pick_coord(), $urandom);
      end
      wait_drained();
    end
    steady = 1'b0;

    repeat (DrainCycles) @(posedge clk_i);
    $display("Checked %0d texel requests over %0d register settings, %0d of them unsupported.",
             n_checked, n_settings, n_unsupported);
    $display("Errors: %0d", err_count);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
